// ===== hw/rtl/bb3g_pkg.sv =====
// ----------------------------------------------------------------------------
// bb3g_pkg
// Shared types and constants for the 3x3 grayscale box blur.
// ----------------------------------------------------------------------------
package bb3g_pkg;

  localparam int PIX_W    = 8;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 12;
  localparam int SUM_W    = 12;   // nine 8-bit pixels
  localparam int RECIP_W  = 13;
  localparam int PROD_W   = SUM_W + RECIP_W;

  // floor(s/9) == (s * 7282) >> 16 for every s up to 9*255
  localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;
  localparam int                 RECIP_SHIFT = 16;

  localparam logic [WIDTH_W-1:0]  WIDTH_MIN  = 11'd3;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = 12'd3;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 12'd480;

  // register indexes (paddr[2])
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // per-item control carried from the counter stage to the window stage
  typedef struct packed {
    logic emit;    // item produces a result
    logic border;  // result pixel lies on the image border
    logic last;    // result is the last of the frame
  } bb3g_ctl_t;

endpackage

// ===== hw/rtl/bb3g_ram.sv =====
// ----------------------------------------------------------------------------
// bb3g_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bb3g_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/bb3g_window.sv =====
// ----------------------------------------------------------------------------
// bb3g_window
// 3x3 window of original pixels; shifts in one column per item and forms
// the result pixel (center on the border, floor(sum/9) inside).
// ----------------------------------------------------------------------------
module bb3g_window (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  shift,
  input  logic [bb3g_pkg::PIX_W-1:0] top,
  input  logic [bb3g_pkg::PIX_W-1:0] mid,
  input  logic [bb3g_pkg::PIX_W-1:0] bot,
  input  bb3g_pkg::bb3g_ctl_t   ctl,
  output logic [bb3g_pkg::PIX_W-1:0] result
);
  import bb3g_pkg::*;

  logic [PIX_W-1:0]  win_r   [3][3];
  logic [PIX_W-1:0]  win_nxt [3][3];
  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;

  // next window: columns move left, new column enters on the right
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_nxt[k][0] = win_r[k][1];
      win_nxt[k][1] = win_r[k][2];
    end
    win_nxt[0][2] = top;
    win_nxt[1][2] = mid;
    win_nxt[2][2] = bot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          win_r[a][b] <= '0;
        end
      end
    end else if (shift) begin
      win_r <= win_nxt;
    end
  end

  // neighborhood sum and divide by nine via reciprocal
  always_comb begin
    sum = '0;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        sum = sum + SUM_W'(win_nxt[a][b]);
      end
    end
    prod = PROD_W'(sum) * PROD_W'(RECIP_NINE);
  end

  assign result = ctl.border ? win_nxt[1][1] : prod[RECIP_SHIFT +: PIX_W];

endmodule

// ===== hw/rtl/box_blur_3x3_gray.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_gray
// Streaming 3x3 mean filter for 8-bit grayscale frames in raster order.
// ----------------------------------------------------------------------------
//   channel | ports                              | direction
//   --------+------------------------------------+----------
//   input   | in_valid in_stall in_pixel_in in_flush  | in
//   result  | out_valid out_stall out_pixel_out out_frame_last | out
//   config  | psel penable pwrite paddr pwdata prdata pready | APB
//
// One item per clock while in_stall is low: the line buffer read issued at
// accept lands in the next cycle in the window stage, which writes both line
// buffers back and loads the result register that the result leaves from.
// Reset clears counters, window and valid flags; line buffers need no clear.
// in_stall rises only when the window stage holds an item and the result
// register is full and stalled.
// ----------------------------------------------------------------------------
module box_blur_3x3_gray #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bb3g_pkg::PIX_W-1:0]    in_pixel_in,
  input  logic                          in_flush,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bb3g_pkg::PIX_W-1:0]    out_pixel_out,
  output logic                          out_frame_last,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import bb3g_pkg::*;

  localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW    = (AW + 1 > HEIGHT_W + 1) ? AW + 1 : HEIGHT_W + 1;
  localparam int ROW_W = HEIGHT_W + 1;   // row runs past height while draining
  localparam logic [WIDTH_W-1:0] WIDTH_RST =
    WIDTH_W'((MAX_WIDTH < 640) ? MAX_WIDTH : 640);

  // configuration registers
  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic                cfg_wr;
  logic [WIDTH_W-1:0]  wval;
  logic [HEIGHT_W-1:0] hval;

  // position counters
  logic [AW-1:0]       col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [AW-1:0]       qc_r, qc_nxt;
  logic [HEIGHT_W-1:0] qr_r, qr_nxt;

  // window stage
  logic                s1_valid_r;
  logic [AW-1:0]       s1_addr_r;
  logic [PIX_W-1:0]    s1_pix_r;
  bb3g_ctl_t           s1_ctl_r;
  logic                s1_fire;

  // result register
  logic                out_valid_r;
  logic [PIX_W-1:0]    out_pixel_r;
  logic                out_last_r;

  logic                accept, idle_flush, work;
  logic [PIX_W-1:0]    pix0;
  bb3g_ctl_t           ctl0;
  logic                col_end, qc_end;
  logic [CW-1:0]       col_inc, w_ext, qc_ext, wm1_ext;
  logic [PIX_W-1:0]    top_q, mid_q, result;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // saturate writes into the legal range
  always_comb begin
    wval = pwdata[WIDTH_W-1:0];
    if (wval < WIDTH_MIN) begin
      wval = WIDTH_MIN;
    end else if (32'(wval) > 32'(MAX_WIDTH)) begin
      wval = WIDTH_W'(MAX_WIDTH);
    end
    hval = pwdata[HEIGHT_W-1:0];
    if (hval < HEIGHT_MIN) begin
      hval = HEIGHT_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_WIDTH:  width_r  <= wval;
        REG_HEIGHT: height_r <= hval;
        default:    ;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(height_r) : 32'(width_r);

  // ---------------- counter stage ----------------
  assign in_stall   = s1_valid_r && out_valid_r && out_stall;
  assign accept     = in_valid && !in_stall;
  assign idle_flush = in_flush && (row_r == '0) && (col_r == '0);
  assign work       = accept && !idle_flush;

  // flush items and drain items carry a zero pixel
  assign pix0 = (in_flush || (row_r >= ROW_W'(height_r))) ? '0 : in_pixel_in;

  assign col_inc = CW'(col_r) + CW'(1);
  assign w_ext   = CW'(width_r);
  assign wm1_ext = w_ext - CW'(1);
  assign qc_ext  = CW'(qc_r);
  assign col_end = (col_inc >= w_ext);
  assign qc_end  = (qc_ext == wm1_ext);

  always_comb begin
    ctl0.emit   = (row_r >= ROW_W'(2)) || ((row_r == ROW_W'(1)) && (col_r != '0));
    ctl0.border = (qr_r == '0) || (qr_r >= height_r - HEIGHT_W'(1)) ||
                  (qc_r == '0) || qc_end;
    ctl0.last   = (qr_r == height_r - HEIGHT_W'(1)) && qc_end;
  end

  // position update; a register write or the last result of a frame restarts it
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    qc_nxt  = qc_r;
    qr_nxt  = qr_r;
    if (cfg_wr || (work && ctl0.emit && ctl0.last)) begin
      col_nxt = '0;
      row_nxt = '0;
      qc_nxt  = '0;
      qr_nxt  = '0;
    end else if (work) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_inc[AW-1:0];
      end
      if (ctl0.emit) begin
        if (qc_end) begin
          qc_nxt = '0;
          qr_nxt = qr_r + HEIGHT_W'(1);
        end else begin
          qc_nxt = qc_r + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      qc_r  <= '0;
      qr_r  <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      qc_r  <= qc_nxt;
      qr_r  <= qr_nxt;
    end
  end

  // ---------------- line buffers ----------------
  bb3g_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_addr_r),
    .wdata (mid_q),
    .re    (work),
    .raddr (col_r),
    .rdata (top_q)
  );

  bb3g_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_addr_r),
    .wdata (s1_pix_r),
    .re    (work),
    .raddr (col_r),
    .rdata (mid_q)
  );

  // ---------------- window stage ----------------
  assign s1_fire = s1_valid_r && !(out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (work) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      s1_addr_r <= col_r;
      s1_pix_r  <= pix0;
      s1_ctl_r  <= ctl0;
    end
  end

  bb3g_window u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .shift  (s1_fire),
    .top    (top_q),
    .mid    (mid_q),
    .bot    (s1_pix_r),
    .ctl    (s1_ctl_r),
    .result (result)
  );

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_ctl_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_ctl_r.emit) begin
      out_pixel_r <= result;
      out_last_r  <= s1_ctl_r.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_out  = out_pixel_r;
  assign out_frame_last = out_last_r;

endmodule

// ===== dv/bb3g_blur_checker.sv =====
// ----------------------------------------------------------------------------
// bb3g_blur_checker
// Watches the box blur channels and config port, predicts every blurred
// pixel from its own copy of the line buffers and window, and compares each
// item that leaves the block with the oldest prediction.
// ----------------------------------------------------------------------------
module bb3g_blur_checker #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [bb3g_pkg::PIX_W-1:0] in_pixel_in,
  input  logic                       in_flush,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [bb3g_pkg::PIX_W-1:0] out_pixel_out,
  input  logic                       out_frame_last,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  input  logic                       pready,
  output int                         n_pending,
  output int                         n_fail
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEIGHT_LIM  = 4095;
  localparam int BLUR_DIV    = 9;
  localparam int MAX_REPORTS = 100;   // keep the log short on a broken build

  typedef struct packed {
    logic [bb3g_pkg::PIX_W-1:0] pixel;
    logic                       frame_end;
  } blur_px_t;

  // predictor state
  int                         img_w;
  int                         img_h;
  logic [bb3g_pkg::PIX_W-1:0] line_far  [MAX_WIDTH];   // two rows back
  logic [bb3g_pkg::PIX_W-1:0] line_near [MAX_WIDTH];   // one row back
  logic [bb3g_pkg::PIX_W-1:0] win [3][3];
  int                         col_pos;
  int                         row_pos;
  int                         n_blurred;
  blur_px_t                   blur_exp_q [$];
  blur_px_t                   exp_px;
  int                         cfg_v;
  int                         n_bad = 0;

  assign n_fail = n_bad;

  task automatic report_mismatch(input string msg);
    if (n_bad < MAX_REPORTS) $display("%0t ns mismatch: %s", $time, msg);
    n_bad++;
  endtask

  task automatic frame_restart();
    col_pos   = 0;
    row_pos   = 0;
    n_blurred = 0;
  endtask

  // one accepted input item: shift the window, maybe queue one blurred pixel
  task automatic blur_predict(input logic [bb3g_pkg::PIX_W-1:0] px_in, input logic is_flush);
    logic [bb3g_pkg::PIX_W-1:0] px, above, middle, val;
    int       c, q, qr, qc, sum, w, h;
    bit       emit;
    blur_px_t res;
    // flush at frame start does nothing
    if (is_flush && row_pos == 0 && col_pos == 0) return;
    w  = img_w;
    h  = img_h;
    px = (is_flush || row_pos >= h) ? '0 : px_in;
    c  = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
    above        = line_far[c];
    middle       = line_near[c];
    line_far[c]  = middle;
    line_near[c] = px;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = above;
    win[1][2] = middle;
    win[2][2] = px;
    emit = (row_pos >= 2) || (row_pos == 1 && col_pos >= 1);
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (!emit) return;
    // result lags by one row plus one pixel
    q  = n_blurred;
    qr = q / w;
    qc = q % w;
    if (qr == 0 || qr >= h - 1 || qc == 0 || qc == w - 1) begin
      val = win[1][1];
    end else begin
      sum = 0;
      foreach (win[a, b]) sum += win[a][b];
      val = 8'(sum / BLUR_DIV);
    end
    res.pixel     = val;
    res.frame_end = (q + 1 >= w * h);
    blur_exp_q.push_back(res);
    if (res.frame_end) frame_restart();
    else n_blurred = q + 1;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      img_w = 640;
      img_h = bb3g_pkg::HEIGHT_RST;
      foreach (line_far[i]) begin
        line_far[i]  = '0;
        line_near[i] = '0;
      end
      foreach (win[a, b]) win[a][b] = '0;
      frame_restart();
      blur_exp_q.delete();
    end else begin
      // register write: saturate and restart the frame
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == bb3g_pkg::REG_WIDTH) begin
          cfg_v = pwdata[bb3g_pkg::WIDTH_W-1:0];
          img_w = (cfg_v < bb3g_pkg::WIDTH_MIN) ? bb3g_pkg::WIDTH_MIN :
                  (cfg_v > MAX_WIDTH) ? MAX_WIDTH : cfg_v;
        end else begin
          cfg_v = pwdata[bb3g_pkg::HEIGHT_W-1:0];
          img_h = (cfg_v < bb3g_pkg::HEIGHT_MIN) ? bb3g_pkg::HEIGHT_MIN :
                  (cfg_v > HEIGHT_LIM) ? HEIGHT_LIM : cfg_v;
        end
        frame_restart();
      end
      if (in_valid && !in_stall) blur_predict(in_pixel_in, in_flush);
      // compare each outgoing item with the oldest prediction
      if (out_valid && !out_stall) begin
        if (blur_exp_q.size() == 0) begin
          report_mismatch($sformatf("unexpected item pixel_out=%0d frame_last=%0b",
                                    out_pixel_out, out_frame_last));
        end else begin
          exp_px = blur_exp_q.pop_front();
          if (out_pixel_out !== exp_px.pixel)
            report_mismatch($sformatf("pixel_out got %0d want %0d",
                                      out_pixel_out, exp_px.pixel));
          if (out_frame_last !== exp_px.frame_end)
            report_mismatch($sformatf("frame_last got %0b want %0b",
                                      out_frame_last, exp_px.frame_end));
        end
      end
    end
    n_pending <= blur_exp_q.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the 3x3 box blur: a short directed frame, then random frames
// under three idling mixes, then short runs at the widest and tallest sizes.
// The checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W         = 1024;
  localparam int HEIGHT_LIM    = 4095;
  localparam int PHASE_ITEMS   = 100;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int EDGE_ITEMS    = 24;

  logic                       clk            = 1'b0;
  logic                       rst_n          = 1'b0;
  logic                       in_valid       = 1'b0;
  logic                       in_stall;
  logic [bb3g_pkg::PIX_W-1:0] in_pixel_in    = '0;
  logic                       in_flush       = 1'b0;
  logic                       out_valid;
  logic                       out_stall      = 1'b0;
  logic [bb3g_pkg::PIX_W-1:0] out_pixel_out;
  logic                       out_frame_last;
  logic                       psel           = 1'b0;
  logic                       penable        = 1'b0;
  logic                       pwrite         = 1'b0;
  logic [2:0]                 paddr          = '0;
  logic [31:0]                pwdata         = '0;
  logic [31:0]                prdata;
  logic                       pready;

  int n_pending;
  int n_fail;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_reqs    = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int cur_w        = 640;
  int cur_h        = 480;
  int n_sent       = 0;
  int goal;
  int n_frames;

  box_blur_3x3_gray #(.MAX_WIDTH(MAX_W)) dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_pixel_in, .in_flush,
    .out_valid, .out_stall, .out_pixel_out, .out_frame_last,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  bb3g_blur_checker #(.MAX_WIDTH(MAX_W)) chk (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_pixel_in, .in_flush,
    .out_valid, .out_stall, .out_pixel_out, .out_frame_last,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .n_pending, .n_fail
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: random stall, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    out_stall <= (hold_left != 0) || ($urandom_range(99) < rcv_idle_pct);
  end

  // run limit
  initial begin
    #4ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [bb3g_pkg::PIX_W-1:0] rand_pix();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  // register value, sometimes with junk above the field
  function automatic logic [31:0] raw_dim(input int v);
    logic [31:0] junk;
    junk = ($urandom_range(3) == 0) ? ($urandom() & 32'hFFFF_F000) : 32'd0;
    return junk | v;
  endfunction

  // offer one item, with random gaps before it, until accepted
  task automatic send_item(input logic [bb3g_pkg::PIX_W-1:0] px, input logic fl);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_pixel_in <= px;
    in_flush    <= fl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop sending until every predicted item is out, then let the pipe settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup + access write; tracks the saturated frame size for framing
  task automatic reg_write(input logic sel, input logic [31:0] val);
    int v;
    if (sel == bb3g_pkg::REG_WIDTH) begin
      v     = val[bb3g_pkg::WIDTH_W-1:0];
      cur_w = (v < 3) ? 3 : (v > MAX_W) ? MAX_W : v;
    end else begin
      v     = val[bb3g_pkg::HEIGHT_W-1:0];
      cur_h = (v < 3) ? 3 : (v > HEIGHT_LIM) ? HEIGHT_LIM : v;
    end
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one frame plus drain; a broken frame is cut short and restarted by a write
  task automatic run_frame(input bit broken, input bit pause_mid);
    int n_px, cut;
    n_px = cur_w * cur_h;
    cut  = broken ? $urandom_range(n_px - 1, 1) : n_px;
    for (int i = 0; i < cut; i++) begin
      if (pause_mid && i == cut / 2) wait_drained();
      // never a flush on the first pixel: it would be dropped
      send_item(rand_pix(), (i != 0) && ($urandom_range(19) == 0));
    end
    n_sent += cut;
    if (broken) begin
      wait_drained();
      reg_write(bb3g_pkg::REG_HEIGHT, cur_h);
    end else begin
      for (int i = 0; i <= cur_w; i++) send_item(rand_pix(), 1'($urandom_range(1)));
      n_sent += cur_w + 1;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 4x3 frame, junk above fields, height clamped up from zero
    reg_write(bb3g_pkg::REG_WIDTH, 32'hFFFF_F804);
    reg_write(bb3g_pkg::REG_HEIGHT, 32'hFFFF_F000);
    send_item(8'hA5, 1'b1);   // flush before any pixel is dropped
    // left interior window all 255; a flush inside the frame counts as 0
    for (int i = 0; i < 12; i++)
      send_item((i == 7) ? 8'h5A : (i % 4 == 3) ? 8'h00 : 8'hFF, i == 7);
    // drain mixes flushes and pixels whose values are ignored
    send_item(8'h00, 1'b1);
    send_item(8'hC3, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'h3C, 1'b0);
    send_item(8'h81, 1'b0);
    // partial frame, then writes restart it
    send_item(8'h12, 1'b0);
    send_item(8'h34, 1'b0);
    wait_drained();
    reg_write(bb3g_pkg::REG_WIDTH, 32'd3);
    reg_write(bb3g_pkg::REG_HEIGHT, 32'd3);

    // random frames under three idling mixes
    for (int ph = 0; ph < 3; ph++) begin
      snd_idle_pct  = (ph == 0) ? 37 : (ph == 1) ? 61 : 0;
      rcv_idle_pct <= (ph == 0) ? 61 : (ph == 1) ? 37 : 0;
      goal     = n_sent + PHASE_ITEMS;
      n_frames = 0;
      while (n_sent < goal) begin
        wait_drained();
        if ($urandom_range(1)) reg_write(bb3g_pkg::REG_WIDTH, raw_dim($urandom_range(8)));
        if ($urandom_range(1)) reg_write(bb3g_pkg::REG_HEIGHT, raw_dim($urandom_range(6)));
        if ($urandom_range(9) == 0) send_item(rand_pix(), 1'b1);
        // long receiver hold while the sender keeps offering
        if (n_frames == 1 && ph != 1) hold_reqs <= hold_reqs + 1;
        run_frame($urandom_range(7) == 0, $urandom_range(5) == 0);
        n_frames++;
      end
    end

    // widest frame, then tallest, each cut short; the widest is restarted by a write
    wait_drained();
    reg_write(bb3g_pkg::REG_WIDTH, 32'hFFFF_FFFF);
    reg_write(bb3g_pkg::REG_HEIGHT, 32'd3);
    for (int i = 0; i < EDGE_ITEMS; i++) send_item(rand_pix(), 1'b0);
    wait_drained();
    reg_write(bb3g_pkg::REG_WIDTH, 32'd3);
    reg_write(bb3g_pkg::REG_HEIGHT, 32'h0000_1FFF);
    for (int i = 0; i < EDGE_ITEMS; i++) send_item(rand_pix(), 1'b0);
    wait_drained();

    if (n_fail == 0 && n_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/bb3g_pkg.sv
hw/rtl/bb3g_ram.sv
hw/rtl/bb3g_window.sv
hw/rtl/box_blur_3x3_gray.sv
dv/bb3g_blur_checker.sv
dv/tb_top.sv
